// ===== sv/bpsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsc_pkg
// Shared types and constants for the backlog PI share controller.
// ----------------------------------------------------------------------------
package bpsc_pkg;

  // Fraction bits of the integral accumulator
  localparam int FRAC_BITS   = 16;
  localparam int INTEG_LIMIT = 1000000;
  localparam int INTEG_W     = 20 + FRAC_BITS;
  localparam logic [INTEG_W-1:0] INTEG_MAX = INTEG_W'(INTEG_LIMIT) << FRAC_BITS;

  // Divider: dividend is |error| with FRAC_BITS zeros appended
  localparam int DVD_W      = 32 + FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(DVD_W);

  // Shared multiplier: 33-bit signed gain times a 17-bit signed chunk
  localparam int CHUNK_W = 16;
  localparam int MA_W    = 33;
  localparam int MB_W    = 3 * CHUNK_W;
  localparam int PP_W    = MA_W + CHUNK_W + 1;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int SUM_W   = 66;

  // Final sum is in signed Q48.16 (64 bits), shares are its integer part
  localparam int SHARE_SHIFT = 16;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 3'd4;

  typedef struct packed {
    logic [31:0]        target_backlog;
    logic signed [31:0] prop_gain;
    logic signed [31:0] integ_gain;
    logic [15:0]        share_floor;
    logic [15:0]        share_ceiling;
  } cfg_t;

  typedef struct packed {
    logic       load_in;
    logic       div_start;
    logic       integ_upd;
    logic       mul_issue;
    logic       mul_op;     // 0: prop_gain * error, 1: integ_gain * integral
    logic [1:0] mul_chunk;
    logic       sum_en;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic elapsed_zero;
    logic div_done;
  } sts_t;

endpackage

// ===== sv/bpsc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpsc_div import bpsc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [31:0]      divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [31:0]          rem;
  logic [DVD_W-1:0]     quo;
  logic [32:0]          trial;
  logic [32:0]          diff;
  logic                 qbit;

  assign trial = {rem, quo[DVD_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign qbit  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem <= qbit ? diff[31:0] : trial[31:0];
        quo <= {quo[DVD_W-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== sv/bpsc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsc_dp
// Datapath: error, divider, integral update, shared multiplier, sum and clamp.
// ----------------------------------------------------------------------------
module bpsc_dp import bpsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  cfg_t        cfg,
  input  logic        integ_clr,
  input  logic [31:0] backlog_sample,
  input  logic [31:0] elapsed_ms,
  output logic [15:0] shares,
  output logic [35:0] integral_now
);

  logic [31:0]         elapsed;
  logic signed [32:0]  err;
  logic [32:0]         err_abs;
  logic [INTEG_W-1:0]  integ;
  logic [INTEG_W-1:0]  integ_next;
  logic [INTEG_W-1:0]  qc;
  logic [INTEG_W:0]    integ_add;
  logic                div_done;
  logic [DVD_W-1:0]    quotient;

  logic signed [MA_W-1:0]    a_op;
  logic [MB_W-1:0]           b_op;
  logic signed [CHUNK_W:0]   b_chunk;
  logic signed [PP_W-1:0]    pp;
  logic                      pp_valid;
  logic                      pp_first;
  logic                      pp_op;
  logic [1:0]                pp_chunk;
  logic signed [PROD_W-1:0]  pp_ext;
  logic signed [PROD_W-1:0]  pp_sh;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  iterm_full;
  logic signed [SUM_W-1:0]   sum_wide;
  logic signed [63:0]        pterm;
  logic signed [63:0]        sum;
  logic signed [63:0]        sum_adj;
  logic signed [63:0]        val;
  logic signed [63:0]        floor_s;
  logic signed [63:0]        ceil_s;
  logic [15:0]               shares_next;
  logic [63:0]               integ_wide;

  // Input latch and error
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      elapsed <= elapsed_ms;
      err     <= $signed({1'b0, backlog_sample}) - $signed({1'b0, cfg.target_backlog});
    end
  end

  assign err_abs = err[32] ? (33'd0 - 33'(err)) : 33'(err);

  bpsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({err_abs[31:0], {FRAC_BITS{1'b0}}}),
    .divisor  (elapsed),
    .done     (div_done),
    .quotient (quotient)
  );

  assign sts.elapsed_zero = (elapsed == 32'd0);
  assign sts.div_done     = div_done;

  // Integral update; an oversized step saturates either way, so clip it first
  always_comb begin
    qc        = (quotient > DVD_W'(INTEG_MAX)) ? INTEG_MAX : quotient[INTEG_W-1:0];
    integ_add = {1'b0, integ} + {1'b0, qc};
    if (sts.elapsed_zero) begin
      if (err[32])
        integ_next = '0;
      else if (err != 33'sd0)
        integ_next = INTEG_MAX;
      else
        integ_next = integ;
    end else if (err[32]) begin
      integ_next = (qc >= integ) ? '0 : integ - qc;
    end else begin
      integ_next = (integ_add > {1'b0, INTEG_MAX}) ? INTEG_MAX : integ_add[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
    end else if (integ_clr) begin
      integ <= '0;
    end else if (cmd.integ_upd) begin
      integ <= integ_next;
    end
  end

  // Shared multiplier, one 16-bit chunk of the wide operand per beat
  always_comb begin
    a_op = cmd.mul_op ? {cfg.integ_gain[31], cfg.integ_gain}
                      : {cfg.prop_gain[31], cfg.prop_gain};
    b_op = cmd.mul_op ? MB_W'(integ) : {{(MB_W-MA_W){err[32]}}, err};
    case (cmd.mul_chunk)
      2'd0:    b_chunk = $signed({1'b0, b_op[CHUNK_W-1:0]});
      2'd1:    b_chunk = $signed({1'b0, b_op[2*CHUNK_W-1:CHUNK_W]});
      default: b_chunk = $signed({b_op[MB_W-1], b_op[MB_W-1:2*CHUNK_W]});
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_valid <= 1'b0;
    end else begin
      pp_valid <= cmd.mul_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_issue) begin
      pp       <= a_op * b_chunk;
      pp_first <= (cmd.mul_chunk == 2'd0);
      pp_op    <= cmd.mul_op;
      pp_chunk <= cmd.mul_chunk;
    end
  end

  assign pp_ext = $signed({{(PROD_W-PP_W){pp[PP_W-1]}}, pp});

  always_comb begin
    case (pp_chunk)
      2'd0:    pp_sh = pp_ext;
      2'd1:    pp_sh = pp_ext <<< CHUNK_W;
      default: pp_sh = pp_ext <<< (2 * CHUNK_W);
    endcase
  end

  always_ff @(posedge clk) begin
    if (pp_valid) begin
      prod <= pp_first ? pp_sh : prod + pp_sh;
      // the proportional product is complete when the integral one starts
      if (pp_first && pp_op)
        pterm <= prod[63:0];
    end
  end

  // Integral term rounds toward minus infinity
  assign iterm_full = prod >>> FRAC_BITS;
  assign sum_wide   = $signed({{(SUM_W-64){pterm[63]}}, pterm}) + iterm_full[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      if (!sum_wide[SUM_W-1] && (sum_wide[SUM_W-2:63] != '0))
        sum <= {1'b0, {63{1'b1}}};
      else if (sum_wide[SUM_W-1] && (sum_wide[SUM_W-2:63] != '1))
        sum <= {1'b1, {63{1'b0}}};
      else
        sum <= sum_wide[63:0];
    end
  end

  // Truncate toward zero, then clamp; floor wins only for values below it
  always_comb begin
    sum_adj = sum + (sum[63] ? ((64'sd1 <<< SHARE_SHIFT) - 64'sd1) : 64'sd0);
    val     = sum_adj >>> SHARE_SHIFT;
    floor_s = $signed({48'd0, cfg.share_floor});
    ceil_s  = $signed({48'd0, cfg.share_ceiling});
    if (val < floor_s)
      shares_next = cfg.share_floor;
    else if (val > ceil_s)
      shares_next = cfg.share_ceiling;
    else
      shares_next = val[15:0];
  end

  assign integ_wide = 64'(integ);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      shares       <= shares_next;
      integral_now <= integ_wide[35:0];
    end
  end

  assert property (@(posedge clk) disable iff (rst) integ <= INTEG_MAX)
    else $error("integral above its upper bound");

endmodule

// ===== sv/bpsc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsc_ctrl
// Sequencer: accept, divide unless elapsed time is zero, update integral, multiply, sum, deliver.
// ----------------------------------------------------------------------------
module bpsc_ctrl import bpsc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_INTEG,
    S_MUL,
    S_DRAIN,
    S_SUM,
    S_FIN
  } state_t;

  state_t     state;
  logic [2:0] cnt;
  logic       out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd           = '0;
    cmd.load_in   = (state == S_IDLE) && s_tvalid;
    cmd.div_start = (state == S_PREP) && !sts.elapsed_zero;
    cmd.integ_upd = (state == S_INTEG);
    cmd.mul_issue = (state == S_MUL);
    cmd.mul_op    = (cnt >= 3'd3);
    cmd.mul_chunk = (cnt >= 3'd3) ? 2'(cnt - 3'd3) : cnt[1:0];
    cmd.sum_en    = (state == S_SUM);
    cmd.load_out  = (state == S_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == S_FIN) && out_free)
        m_tvalid <= 1'b1;
      else if (m_tready)
        m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid)
            state <= S_PREP;
        end
        S_PREP: begin
          state <= sts.elapsed_zero ? S_INTEG : S_DIV;
        end
        S_DIV: begin
          if (sts.div_done)
            state <= S_INTEG;
        end
        S_INTEG: begin
          cnt   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd5)
            state <= S_DRAIN;
        end
        S_DRAIN: begin
          state <= S_SUM;
        end
        S_SUM: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free)
            state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("result overwritten while waiting");

  assert property (@(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> !s_tready)
    else $error("second beat taken while busy");

  assert property (@(posedge clk) disable iff (rst) sts.div_done |-> (state == S_DIV))
    else $error("divider finished outside divide phase");

endmodule

// ===== sv/backlog_pi_share_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backlog_pi_share_controller_top
// PI controller turning backlog samples into clamped scheduling shares.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one sample per beat (backlog and milliseconds since the last
//   sample); m_* returns one beat per sample with the share value and the
//   updated integral. cfg_* writes the five registers; a write of the
//   setpoint or either gain clears the integral. Write only while idle.
//   Each sample passes the restoring divider, one quotient bit per
//   cycle, then the integral update, the shared multiplier and the
//   sum; a zero elapsed time skips the divider.
//   One sample is in flight at a time; s_tready is high when idle.
//   The result sits in an output register, so a new sample is taken while
//   the previous result waits; a stalled receiver holds the next result in
//   the final step until the register is free.
//   Reset clears the integral and loads the register defaults
//   (floor 1, ceiling 1000, setpoint and gains 0).
// ----------------------------------------------------------------------------
module backlog_pi_share_controller_top import bpsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [63:0]          s_tdata,   // backlog_sample[31:0], elapsed_ms[63:32]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [55:0]          m_tdata,   // shares[15:0], integral_now[51:16], zero pad
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t        cfg;
  cmd_t        cmd;
  sts_t        sts;
  logic        cfg_we;
  logic        integ_clr;
  logic [15:0] shares;
  logic [35:0] integral_now;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign integ_clr = cfg_we && ((cfg_index == CFG_TARGET) || (cfg_index == CFG_PROP) ||
                                (cfg_index == CFG_INTEG));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_backlog <= 32'd0;
      cfg.prop_gain      <= 32'sd0;
      cfg.integ_gain     <= 32'sd0;
      cfg.share_floor    <= 16'd1;
      cfg.share_ceiling  <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET:  cfg.target_backlog <= cfg_data;
        CFG_PROP:    cfg.prop_gain      <= $signed(cfg_data);
        CFG_INTEG:   cfg.integ_gain     <= $signed(cfg_data);
        CFG_FLOOR:   cfg.share_floor    <= cfg_data[15:0];
        CFG_CEILING: cfg.share_ceiling  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  bpsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  bpsc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg            (cfg),
    .integ_clr      (integ_clr),
    .backlog_sample (s_tdata[31:0]),
    .elapsed_ms     (s_tdata[63:32]),
    .shares         (shares),
    .integral_now   (integral_now)
  );

  assign m_tdata = {4'd0, integral_now, shares};

endmodule

// ===== bench/tb_backlog_pi_share_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_backlog_pi_share_controller_top
// Self-checking bench for the backlog PI share controller.
// A directed table runs first: reset defaults, zero elapsed time, clamping,
// a floor above the ceiling, the integral clear on a setpoint or gain write,
// and writes to unused register indexes. Random phases with varied gains,
// setpoints and share limits follow. Expected beats come from the table or a
// software model of the controller, and are compared field by field.
// ----------------------------------------------------------------------------
module tb_backlog_pi_share_controller_top;
  import bpsc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [15:0] shares;
    logic [35:0] integ;
  } share_beat_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [31:0]            a;
    logic [31:0]            b;
    bit                     typed;
    share_beat_t            beat;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [63:0]          s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [55:0]          m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  backlog_pi_share_controller_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Controller model state
  logic [31:0]        tgt_backlog_m = '0;
  logic signed [31:0] kp_m = '0;
  logic signed [31:0] ki_m = '0;
  logic [15:0]        floor_m = 16'd1;
  logic [15:0]        ceil_m = 16'd1000;
  logic [63:0]        integ_m = '0;

  share_beat_t shares_due_q[$];
  stim_row_t   stim_rows[$];

  int errors    = 0;
  int n_samples = 0;
  int n_writes  = 0;
  int n_results = 0;
  int send_idle = 29;
  int recv_idle = 67;
  int cycles    = 0;

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [31:0] val);
    case (idx)
      CFG_TARGET: begin
        tgt_backlog_m = val;
        integ_m = '0;
      end
      CFG_PROP: begin
        kp_m = val;
        integ_m = '0;
      end
      CFG_INTEG: begin
        ki_m = val;
        integ_m = '0;
      end
      CFG_FLOOR:   floor_m = val[15:0];
      CFG_CEILING: ceil_m = val[15:0];
      default: ;
    endcase
  endfunction

  function automatic share_beat_t predict_share(input logic [31:0] smp,
                                                input logic [31:0] el);
    logic signed [33:0] err;
    logic [32:0]        mag;
    logic [63:0]        quot;
    logic [63:0]        acc;
    logic signed [65:0] pterm, iterm, fprod, ipart, fpart, sum, val, lim_hi, lim_lo;
    share_beat_t        r;
    err = $signed({2'b00, smp}) - $signed({2'b00, tgt_backlog_m});
    mag = (err < 0) ? 33'(-err) : 33'(err);
    acc = integ_m;
    if (el == '0) begin
      // no time has passed: pin the integral towards the sign of the error
      if (err > 0) acc = 64'(INTEG_MAX);
      else if (err < 0) acc = '0;
    end else begin
      quot = ({31'd0, mag} << FRAC_BITS) / {32'd0, el};
      if (err < 0) begin
        acc = (quot >= acc) ? 64'd0 : acc - quot;
      end else begin
        acc = acc + quot;
        if (acc > 64'(INTEG_MAX)) acc = 64'(INTEG_MAX);
      end
    end
    integ_m = acc;

    pterm = kp_m * err;
    ipart = $signed({2'b00, acc >> FRAC_BITS});
    fpart = $signed({2'b00, acc & ((64'd1 << FRAC_BITS) - 64'd1)});
    fprod = ki_m * fpart;
    iterm = ki_m * ipart + (fprod >>> FRAC_BITS);

    lim_hi = $signed({3'b000, {63{1'b1}}});
    lim_lo = -lim_hi - 66'sd1;
    sum = pterm + iterm;
    if (sum > lim_hi) sum = lim_hi;
    else if (sum < lim_lo) sum = lim_lo;

    val = sum / 66'sd65536;
    if (val < $signed({50'd0, floor_m})) val = $signed({50'd0, floor_m});
    else if (val > $signed({50'd0, ceil_m})) val = $signed({50'd0, ceil_m});

    r.shares = val[15:0];
    r.integ  = acc[35:0];
    return r;
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    stim_row_t row;
    row.kind  = ROW_WRITE;
    row.idx   = idx;
    row.a     = val;
    row.b     = '0;
    row.typed = 1'b0;
    row.beat  = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_sample(input logic [31:0] smp, input logic [31:0] el);
    stim_row_t row;
    row.kind  = ROW_SAMPLE;
    row.idx   = '0;
    row.a     = smp;
    row.b     = el;
    row.typed = 1'b0;
    row.beat  = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_checked(input logic [31:0] smp, input logic [31:0] el,
                                      input logic [15:0] shares, input logic [35:0] integ);
    stim_row_t row;
    row.kind        = ROW_SAMPLE;
    row.idx         = '0;
    row.a           = smp;
    row.b           = el;
    row.typed       = 1'b1;
    row.beat.shares = shares;
    row.beat.integ  = integ;
    stim_rows.push_back(row);
  endfunction

  // Register writes wait for the block to go idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    s_tvalid <= 1'b0;
    while (shares_due_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg_write(idx, val);
    n_writes++;
  endtask

  task automatic push_sample(input logic [31:0] smp, input logic [31:0] el,
                             input bit typed, input share_beat_t typed_beat);
    share_beat_t pred;
    cfg_valid <= 1'b0;
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {el, smp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = predict_share(smp, el);
    shares_due_q.push_back(typed ? typed_beat : pred);
    n_samples++;
  endtask

  always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= recv_idle);

  // Result beats against the oldest prediction
  always @(posedge clk) begin : result_check
    share_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (shares_due_q.size() == 0) begin
        $error("unexpected result beat: m_tdata %h", m_tdata);
        errors++;
      end else begin
        want = shares_due_q.pop_front();
        if (m_tdata[15:0] !== want.shares) begin
          $error("shares: expected %0d, got %0d", want.shares, m_tdata[15:0]);
          errors++;
        end
        if (m_tdata[51:16] !== want.integ) begin
          $error("integral_now: expected %0d, got %0d", want.integ, m_tdata[51:16]);
          errors++;
        end
        if (m_tdata[55:52] !== 4'd0) begin
          $error("pad: expected 0, got %0h", m_tdata[55:52]);
          errors++;
        end
        n_results++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int          r;
    logic [31:0] v;
    logic [31:0] smp;
    logic [31:0] el;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    add_checked(32'd0, 32'd0, 16'd1, 36'd0);
    add_checked(32'hFFFF_FFFF, 32'd0, 16'd1, INTEG_MAX);
    add_checked(32'd0, 32'hFFFF_FFFF, 16'd1, INTEG_MAX);
    add_write(CFG_TARGET, 32'd1000);
    add_checked(32'd0, 32'd0, 16'd1, 36'd0);
    add_checked(32'd1000, 32'd1, 16'd1, 36'd0);
    add_checked(32'd1001, 32'd1, 16'd1, 36'd65536);
    add_write(CFG_PROP, 32'd65536);
    add_write(CFG_FLOOR, 32'd0);
    add_write(CFG_CEILING, 32'd65535);
    add_checked(32'd1500, 32'd1000, 16'd500, 36'd32768);
    add_checked(32'd500, 32'd1000, 16'd0, 36'd0);
    add_write(CFG_INTEG, 32'h7FFF_FFFF);
    add_write(CFG_PROP, 32'h8000_0000);
    add_sample(32'hFFFF_FFFF, 32'd0);
    add_sample(32'd0, 32'd0);
    add_sample(32'hA5A5_A5A5, 32'h5A5A_5A5A);
    add_sample(32'h5A5A_5A5A, 32'd1);
    add_write(CFG_TARGET, 32'hFFFF_FFFF);
    add_write(CFG_PROP, 32'h7FFF_FFFF);
    add_write(CFG_INTEG, 32'h8000_0000);
    add_sample(32'd0, 32'd1);
    add_sample(32'hFFFF_FFFF, 32'd7);
    add_sample(32'h1234_5678, 32'd0);
    // floor above ceiling
    add_write(CFG_TARGET, 32'd0);
    add_write(CFG_PROP, 32'd65536);
    add_write(CFG_INTEG, 32'd0);
    add_write(CFG_FLOOR, 32'd2000);
    add_write(CFG_CEILING, 32'd100);
    add_checked(32'd50, 32'd10, 16'd2000, 36'd327680);
    add_checked(32'd3000, 32'd10, 16'd100, 36'd19988480);
    add_checked(32'd1500, 32'd0, 16'd2000, INTEG_MAX);
    // unused indexes must leave registers and integral alone
    add_write(CFG_SPARE_LO, 32'hFFFF_FFFF);
    add_write(CFG_SPARE_HI, 32'hFFFF_FFFF);
    add_checked(32'd0, 32'd0, 16'd2000, INTEG_MAX);
    add_write(CFG_FLOOR, 32'hFFFF_FFFF);
    add_write(CFG_CEILING, 32'h0000_FFFF);
    add_write(CFG_INTEG, 32'h0000_0100);
    add_sample(32'd100, 32'hFFFF_FFFF);
    add_sample(32'hFFFF_FFFE, 32'd3);
    add_write(CFG_FLOOR, 32'd0);
    add_write(CFG_INTEG, 32'hFFFF_FF00);
    add_sample(32'd1000, 32'd3);
    add_sample(32'd7, 32'd2);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_WRITE) write_reg(stim_rows[i].idx, stim_rows[i].a);
      else push_sample(stim_rows[i].a, stim_rows[i].b, stim_rows[i].typed, stim_rows[i].beat);
    end

    // Random phases: four per pacing mix
    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 4) begin
        send_idle = 67;
        recv_idle = 29;
      end else if (phase == 8) begin
        send_idle = 0;
        recv_idle = 0;
      end

      // most phases rewrite setpoint and gains, the rest keep the integral
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 3))
          0:       v = 32'd0;
          1:       v = 32'hFFFF_FFFF;
          2:       v = $urandom;
          default: v = $urandom_range(0, 100000);
        endcase
        write_reg(CFG_TARGET, v);
        case ($urandom_range(0, 4))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = $urandom;
          default: v = $urandom_range(0, 262144);
        endcase
        if ($urandom_range(0, 1)) v = -v;
        write_reg(CFG_PROP, v);
        case ($urandom_range(0, 4))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = $urandom;
          default: v = $urandom_range(0, 4096);
        endcase
        if ($urandom_range(0, 1)) v = -v;
        write_reg(CFG_INTEG, v);
      end
      write_reg(CFG_FLOOR, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 50));
      write_reg(CFG_CEILING,
                ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(500, 5000));

      for (int k = 0; k < 42; k++) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          // samples around the setpoint, as a settled loop would see
          smp = tgt_backlog_m + 32'($urandom_range(0, 4000)) - 32'd2000;
          el  = (r < 70) ? 32'($urandom_range(1, 3000)) : 32'd0;
        end else begin
          smp = $urandom;
          el  = (r < 90) ? $urandom : 32'($urandom_range(0, 3));
        end
        push_sample(smp, el, 1'b0, '0);
      end
    end

    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (shares_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d samples and %0d register writes; %0d result beats checked",
             n_samples, n_writes, n_results);
    $display("Stalls on each side in turn, then back-to-back beats, across varied gains");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
